// ----- rtl/stos_pkg.sv -----
// Package for the sigma threshold outlier select block.
// Holds sizing constants and derived arithmetic widths; no dependencies.
`timescale 1ns / 1ps

package stos_pkg;

    // Set capacity and sample precision.
    localparam int MAX_POINTS   = 64;
    localparam int SAMPLE_WIDTH = 16;

    // Fixed widths of the channel fields.
    localparam int INTENSITY_W = 16;
    localparam int SIGMA_W     = 4;
    localparam int SIGMA_RESET = 7;

    // Fraction bits of the mean and the deviation.
    localparam int FRAC_W = 8;

    // Store addressing and sample count.
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    // Sum of samples, sum of squares and the scaled sum of squares.
    localparam int SUM_W  = SAMPLE_WIDTH + IDX_W;
    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int SQ_W   = PROD_W + IDX_W;
    localparam int NS2_W  = SQ_W + CNT_W;

    // Radicand of the square root, padded to an even width.
    localparam int A_W    = NS2_W + 2 * FRAC_W;
    localparam int RAD_W  = A_W + (A_W % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    // Shared divider operand width and the threshold width.
    localparam int DIV_W  = (ROOT_W > SUM_W + FRAC_W) ? ROOT_W : SUM_W + FRAC_W;
    localparam int DR_W   = CNT_W + 1;
    localparam int STEP_W = $clog2(DIV_W);
    localparam int KS_W   = DIV_W + SIGMA_W;
    localparam int THR_W  = KS_W + 1;

endpackage

// ----- rtl/stos_if.sv -----
// Channel interfaces of the sigma threshold outlier select block.
// Depends on stos_pkg for the field widths.
`timescale 1ns / 1ps

// Sample channel: one intensity per transfer, with the end-of-set mark.
interface stos_in_if;
    import stos_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [INTENSITY_W-1:0] intensity;
    logic                   last_sample;

    modport source (output valid, output intensity, output last_sample, input ready);
    modport sink   (input valid, input intensity, input last_sample, output ready);
endinterface

// Result channel: one selected index per transfer.
interface stos_out_if;
    import stos_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] point_index;
    logic             found;
    logic             overflow;
    logic             last_result;

    modport source (output valid, output point_index, output found, output overflow,
                     output last_result, input ready);
    modport sink   (input valid, input point_index, input found, input overflow,
                    input last_result, output ready);
endinterface

// Configuration channel: write data of the sigma multiple register.
interface stos_cfg_if;
    import stos_pkg::*;

    logic               valid;
    logic               ready;
    logic [SIGMA_W-1:0] sigma_multiple;

    modport source (output valid, output sigma_multiple, input ready);
    modport sink   (input valid, input sigma_multiple, output ready);
endinterface

// ----- rtl/sigma_threshold_outlier_select.sv -----
// Top level of the sigma threshold outlier select block.
// Depends on stos_pkg and the channel interfaces in stos_if.sv.
`timescale 1ns / 1ps

// Samples are taken one per cycle into a 64-entry sample memory until the sample
// marked last; further samples of a full set are dropped and reported through the
// overflow bit. The set is then evaluated with no samples accepted: a pass over the
// memory sums the squares, two products and a subtraction form the scaled variance,
// a bit-serial square root follows, one shared serial divider yields the deviation
// and the mean, and a select pass reads the memory again, sample by sample, in a
// read state and a compare state. Both passes use the single registered read port
// of the memory, and the select pass waits while the result channel stalls. Results
// come out in ascending index order; the final one carries last_result, and a set
// with no sample above mean plus sigma_multiple deviations gives one result with
// found low. The configuration channel is always ready.
module sigma_threshold_outlier_select (
    input  logic        clk,
    input  logic        rst_n,
    stos_cfg_if.sink    cfg,
    stos_in_if.sink     samples,
    stos_out_if.source  results
);
    import stos_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SQ,
        ST_MUL,
        ST_SUB,
        ST_SQRT,
        ST_DIV_STD,
        ST_DIV_MEAN,
        ST_THR,
        ST_SEL_RD,
        ST_SEL_CMP,
        ST_SEL_END
    } state_t;

    // Sample memory with a registered read port.
    logic [SAMPLE_WIDTH-1:0] mem [MAX_POINTS];
    logic [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic                    wr_en;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;

    // Control and accumulation registers.
    state_t                  state_reg;
    logic [SIGMA_W-1:0]      sigma_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic                    dropped_reg;
    logic [CNT_W-1:0]        issue_reg;
    logic                    d1_reg;
    logic                    d2_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [SQ_W-1:0]         s2_reg;
    logic [NS2_W-1:0]        ns2_reg;
    logic [2*SUM_W-1:0]      s1sq_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [REM_W-1:0]        sq_rem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [DIV_W-1:0]        dq_reg;
    logic [CNT_W-1:0]        dv_rem_reg;
    logic [DIV_W-1:0]        std_reg;
    logic [DIV_W-1:0]        mean_reg;
    logic [THR_W-1:0]        thr_reg;
    logic [IDX_W-1:0]        scan_reg;
    logic [IDX_W-1:0]        pend_idx_reg;
    logic                    pend_valid_reg;

    // Output register.
    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic                    out_found_reg;
    logic                    out_ovf_reg;
    logic                    out_last_reg;

    // Combinational helpers.
    logic [SAMPLE_WIDTH-1:0] x_in;
    logic                    room;
    logic [CNT_W-1:0]        n_val;
    logic [NS2_W-1:0]        diff;
    logic [REM_W-1:0]        sq_rem_sh;
    logic [REM_W-1:0]        sq_trial;
    logic                    sq_ge;
    logic [REM_W-1:0]        sq_rem_step;
    logic [ROOT_W-1:0]       root_step;
    logic [DR_W-1:0]         dv_rs;
    logic                    dv_ge;
    logic [CNT_W-1:0]        dv_rem_step;
    logic [DIV_W-1:0]        dq_step;
    logic [KS_W-1:0]         ks;
    logic                    pass;
    logic                    scan_last;
    logic                    out_free;
    logic                    sel_go;
    logic                    out_load;

    // Handshake outputs.
    assign cfg.ready           = 1'b1;
    assign samples.ready       = (state_reg == ST_LOAD);
    assign results.valid       = out_valid_reg;
    assign results.point_index = out_idx_reg;
    assign results.found       = out_found_reg;
    assign results.overflow    = out_ovf_reg;
    assign results.last_result = out_last_reg;

    // Input sample and store capacity.
    assign x_in  = SAMPLE_WIDTH'(samples.intensity);
    assign room  = (count_reg < CNT_W'(MAX_POINTS));
    assign n_val = (count_reg == '0) ? CNT_W'(1) : count_reg;

    // Memory port control: writes while loading, reads in both passes.
    assign wr_en   = (state_reg == ST_LOAD) && samples.valid && room;
    assign rd_en   = ((state_reg == ST_SQ) && (issue_reg < count_reg))
                     || (state_reg == ST_SEL_RD);
    assign rd_addr = (state_reg == ST_SQ) ? issue_reg[IDX_W-1:0] : scan_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= x_in;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Scaled variance numerator; never negative for a real set.
    assign diff = ns2_reg - NS2_W'(s1sq_reg);

    // One step of the restoring square root, two radicand bits a step.
    assign sq_rem_sh   = {sq_rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign sq_trial    = REM_W'({root_reg, 2'b01});
    assign sq_ge       = (sq_rem_sh >= sq_trial);
    assign sq_rem_step = sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
    assign root_step   = {root_reg[ROOT_W-2:0], sq_ge};

    // One step of the restoring divider by the sample count.
    assign dv_rs       = {dv_rem_reg, dq_reg[DIV_W-1]};
    assign dv_ge       = (dv_rs >= DR_W'(n_val));
    assign dv_rem_step = dv_ge ? CNT_W'(dv_rs - DR_W'(n_val)) : CNT_W'(dv_rs);
    assign dq_step     = {dq_reg[DIV_W-2:0], dv_ge};

    // Deviation term of the threshold.
    assign ks = sigma_reg * std_reg;

    // Select pass decisions.
    assign pass      = (THR_W'({rd_data_reg, {FRAC_W{1'b0}}}) > thr_reg);
    assign scan_last = ((CNT_W'(scan_reg) + CNT_W'(1)) >= count_reg);
    assign out_free  = !out_valid_reg || results.ready;
    assign sel_go    = !pass || !pend_valid_reg || out_free;

    // The output register takes a new result when the select pass hands one over.
    assign out_load  = ((state_reg == ST_SEL_CMP) && sel_go && pass && pend_valid_reg)
                       || ((state_reg == ST_SEL_END) && out_free);

    // Sequencer, datapath registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            sigma_reg      <= SIGMA_W'(SIGMA_RESET);
            count_reg      <= '0;
            sum_reg        <= '0;
            dropped_reg    <= 1'b0;
            issue_reg      <= '0;
            d1_reg         <= 1'b0;
            d2_reg         <= 1'b0;
            prod_reg       <= '0;
            s2_reg         <= '0;
            ns2_reg        <= '0;
            s1sq_reg       <= '0;
            rad_reg        <= '0;
            sq_rem_reg     <= '0;
            root_reg       <= '0;
            step_reg       <= '0;
            dq_reg         <= '0;
            dv_rem_reg     <= '0;
            std_reg        <= '0;
            mean_reg       <= '0;
            thr_reg        <= '0;
            scan_reg       <= '0;
            pend_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_idx_reg    <= '0;
            out_found_reg  <= 1'b0;
            out_ovf_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // Configuration write.
            if (cfg.valid)
            begin
                sigma_reg <= cfg.sigma_multiple;
            end

            // The output register is filled by the select pass and freed by a transfer.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                // Store samples and keep the running sum.
                ST_LOAD:
                begin
                    if (samples.valid)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                            sum_reg   <= sum_reg + SUM_W'(x_in);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (samples.last_sample)
                        begin
                            issue_reg <= '0;
                            d1_reg    <= 1'b0;
                            d2_reg    <= 1'b0;
                            s2_reg    <= '0;
                            state_reg <= ST_SQ;
                        end
                    end
                end

                // Read, square and accumulate every stored sample.
                ST_SQ:
                begin
                    if (rd_en)
                    begin
                        issue_reg <= issue_reg + CNT_W'(1);
                    end
                    d1_reg   <= rd_en;
                    d2_reg   <= d1_reg;
                    prod_reg <= rd_data_reg * rd_data_reg;
                    if (d2_reg)
                    begin
                        s2_reg <= s2_reg + SQ_W'(prod_reg);
                    end
                    if ((issue_reg == count_reg) && !d1_reg && !d2_reg)
                    begin
                        state_reg <= ST_MUL;
                    end
                end

                // n times the sum of squares, and the squared sum.
                ST_MUL:
                begin
                    ns2_reg   <= n_val * s2_reg;
                    s1sq_reg  <= sum_reg * sum_reg;
                    state_reg <= ST_SUB;
                end

                // Scale the variance numerator by 2^16 and start the root.
                ST_SUB:
                begin
                    rad_reg    <= RAD_W'({diff, {(2 * FRAC_W){1'b0}}});
                    sq_rem_reg <= '0;
                    root_reg   <= '0;
                    step_reg   <= '0;
                    state_reg  <= ST_SQRT;
                end

                // Square root, one result bit a cycle.
                ST_SQRT:
                begin
                    sq_rem_reg <= sq_rem_step;
                    root_reg   <= root_step;
                    rad_reg    <= {rad_reg[RAD_W-3:0], 2'b00};
                    if (step_reg == STEP_W'(ROOT_W - 1))
                    begin
                        dq_reg     <= DIV_W'(root_step);
                        dv_rem_reg <= '0;
                        step_reg   <= '0;
                        state_reg  <= ST_DIV_STD;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end

                // Deviation: root divided by the count.
                ST_DIV_STD:
                begin
                    if (step_reg == STEP_W'(DIV_W - 1))
                    begin
                        std_reg    <= dq_step;
                        dq_reg     <= DIV_W'({sum_reg, {FRAC_W{1'b0}}});
                        dv_rem_reg <= '0;
                        step_reg   <= '0;
                        state_reg  <= ST_DIV_MEAN;
                    end
                    else
                    begin
                        dq_reg     <= dq_step;
                        dv_rem_reg <= dv_rem_step;
                        step_reg   <= step_reg + STEP_W'(1);
                    end
                end

                // Mean: scaled sum divided by the count.
                ST_DIV_MEAN:
                begin
                    dq_reg     <= dq_step;
                    dv_rem_reg <= dv_rem_step;
                    step_reg   <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_W - 1))
                    begin
                        mean_reg  <= dq_step;
                        state_reg <= ST_THR;
                    end
                end

                // Threshold and start of the select pass.
                ST_THR:
                begin
                    thr_reg        <= THR_W'(mean_reg) + THR_W'(ks);
                    scan_reg       <= '0;
                    pend_valid_reg <= 1'b0;
                    state_reg      <= ST_SEL_RD;
                end

                // The read of the current sample is issued here.
                ST_SEL_RD:
                begin
                    state_reg <= ST_SEL_CMP;
                end

                // Compare; a passing sample is held back until the next one
                // shows whether it is the final result.
                ST_SEL_CMP:
                begin
                    if (sel_go)
                    begin
                        if (pass)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_idx_reg   <= pend_idx_reg;
                                out_found_reg <= 1'b1;
                                out_ovf_reg   <= dropped_reg;
                                out_last_reg  <= 1'b0;
                            end
                            pend_idx_reg   <= scan_reg;
                            pend_valid_reg <= 1'b1;
                        end
                        if (scan_last)
                        begin
                            state_reg <= ST_SEL_END;
                        end
                        else
                        begin
                            scan_reg  <= scan_reg + IDX_W'(1);
                            state_reg <= ST_SEL_RD;
                        end
                    end
                end

                // Final result of the set, then clear the set state.
                ST_SEL_END:
                begin
                    if (out_free)
                    begin
                        out_idx_reg    <= pend_valid_reg ? pend_idx_reg : '0;
                        out_found_reg  <= pend_valid_reg;
                        out_ovf_reg    <= dropped_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        count_reg      <= '0;
                        sum_reg        <= '0;
                        dropped_reg    <= 1'b0;
                        state_reg      <= ST_LOAD;
                    end
                end

                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

// ----- tb/tb_sigma_threshold_outlier_select.sv -----
`timescale 1ns / 1ps
// Testbench for sigma_threshold_outlier_select: a directed stimulus table, then random sample sets.
// Results are checked against a mean-plus-k-sigma outlier predictor kept in this file, or against a typed row's own.
// Depends on stos_pkg, the channel interfaces in stos_if.sv and the block's top level.

module tb_sigma_threshold_outlier_select;
    import stos_pkg::*;

    localparam int     CLK_HALF_NS   = 6;
    localparam int     RESET_CYCLES  = 11;
    localparam int     RANDOM_ITEMS  = 260;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     TAIL_CYCLES   = 400;
    localparam longint RUN_LIMIT_NS  = 64'd6_000_000;

    typedef struct packed {
        logic [IDX_W-1:0] point_index;
        logic             found;
        logic             overflow;
        logic             last_result;
    } outlier_t;

    typedef enum logic {ROW_SIGMA, ROW_SAMPLE} row_kind_t;

    typedef enum int unsigned {SHAPE_UNIFORM, SHAPE_CLUSTER, SHAPE_FLAT, SHAPE_SPIKY} set_shape_t;

    // One table row: a register write, or a sample repeated reps times.
    // The last mark applies to the final repetition only.
    typedef struct packed {
        row_kind_t              kind;
        logic [INTENSITY_W-1:0] value;
        logic                   last;
        logic [7:0]             reps;
        logic                   typed;
        outlier_t               want;
    } stim_row_t;

    localparam int N_ROWS = 24;

    // Rows with typed set their own expectation; all others go through the predictor.
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        // Single full-scale sample right after reset: zero deviation, nothing passes.
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, 8'd1,  1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}},
        // Extremes pair at the reset multiple: threshold far above the maximum.
        '{ROW_SAMPLE, 16'h0000, 1'b0, 8'd1,  1'b0, '0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, 8'd1,  1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}},
        // Multiple of zero: the threshold is the mean, so the maximum passes.
        '{ROW_SIGMA,  16'd0,    1'b0, 8'd1,  1'b0, '0},
        '{ROW_SAMPLE, 16'h0000, 1'b0, 8'd1,  1'b0, '0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, 8'd1,  1'b1, '{6'd1, 1'b1, 1'b0, 1'b1}},
        '{ROW_SAMPLE, 16'd100,  1'b0, 8'd1,  1'b0, '0},
        '{ROW_SAMPLE, 16'd200,  1'b0, 8'd1,  1'b0, '0},
        '{ROW_SAMPLE, 16'd50000, 1'b0, 8'd1, 1'b0, '0},
        '{ROW_SAMPLE, 16'd300,  1'b1, 8'd1,  1'b0, '0},
        // Largest multiple with one spike among many small samples.
        '{ROW_SIGMA,  16'd15,   1'b0, 8'd1,  1'b0, '0},
        '{ROW_SAMPLE, 16'd1,    1'b0, 8'd20, 1'b0, '0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, 8'd1,  1'b0, '0},
        // Full store of zeros, then a dropped last sample still starts evaluation.
        '{ROW_SAMPLE, 16'h0000, 1'b0, 8'd64, 1'b0, '0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, 8'd1,  1'b1, '{6'd0, 1'b0, 1'b1, 1'b1}},
        // The drop flag must not leak into the next set.
        '{ROW_SAMPLE, 16'd5,    1'b1, 8'd1,  1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}},
        // Multiple of one: the maximum lands exactly on the threshold and fails.
        '{ROW_SIGMA,  16'd1,    1'b0, 8'd1,  1'b0, '0},
        '{ROW_SAMPLE, 16'h0000, 1'b0, 8'd1,  1'b0, '0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, 8'd1,  1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}},
        // Several outliers in one set come out in ascending order.
        '{ROW_SIGMA,  16'd0,    1'b0, 8'd1,  1'b0, '0},
        '{ROW_SAMPLE, 16'h0000, 1'b0, 8'd2,  1'b0, '0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 8'd2,  1'b0, '0},
        '{ROW_SAMPLE, 16'h0000, 1'b1, 8'd1,  1'b0, '0},
        '{ROW_SIGMA,  16'd7,    1'b0, 8'd1,  1'b0, '0}
    };

    logic clk;
    logic rst_n;

    stos_cfg_if cfg_bus ();
    stos_in_if  sample_bus ();
    stos_out_if result_bus ();

    sigma_threshold_outlier_select dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .samples (sample_bus),
        .results (result_bus)
    );

    // Predictor state: the kept samples of the open set and the register copy.
    logic [SAMPLE_WIDTH-1:0] kept_samples [MAX_POINTS];
    int unsigned             kept_count   = 0;
    longint unsigned         kept_sum     = 0;
    logic                    kept_dropped = 1'b0;
    logic [SIGMA_W-1:0]      model_sigma  = SIGMA_W'(SIGMA_RESET);

    outlier_t pending_outliers [$];
    int       mismatch_count = 0;
    int       send_idle_pct  = 30;
    int       recv_idle_pct  = 78;

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    // Hard limit on the run time in case the block stalls.
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Folds one accepted sample into the open set. On the last sample it evaluates the set
    // and, when keep is set, queues the outlier indices that the block should emit.
    function automatic void predict_outliers(input logic [SAMPLE_WIDTH-1:0] x,
                                             input logic last, input logic keep);
        longint unsigned n, sq_sum, radicand, root, trial, mean_q8, std_q8, threshold, v;
        int       i;
        int       b;
        outlier_t held;
        logic     have_held;

        if (kept_count < MAX_POINTS) begin
            kept_samples[kept_count] = x;
            kept_count++;
            kept_sum += 64'(x);
        end else begin
            kept_dropped = 1'b1;
        end
        if (!last) return;

        n = (kept_count == 0) ? 64'd1 : 64'(kept_count);
        sq_sum = 0;
        for (i = 0; i < kept_count; i++) begin
            v = 64'(kept_samples[i]);
            sq_sum += v * v;
        end

        // Exact integer square root of the scaled variance numerator.
        radicand = (n * sq_sum - kept_sum * kept_sum) << 16;
        root = 0;
        for (b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) root = trial;
        end
        mean_q8   = (kept_sum << 8) / n;
        std_q8    = root / n;
        threshold = mean_q8 + 64'(model_sigma) * std_q8;

        // Each hit is held back one step so the final one can carry the last mark.
        have_held = 1'b0;
        held = '0;
        for (i = 0; i < kept_count; i++) begin
            v = 64'(kept_samples[i]);
            if ((v << 8) > threshold) begin
                if (have_held && keep) pending_outliers = {pending_outliers, held};
                held.point_index = IDX_W'(i);
                held.found       = 1'b1;
                held.overflow    = kept_dropped;
                held.last_result = 1'b0;
                have_held = 1'b1;
            end
        end
        if (!have_held) begin
            held.point_index = '0;
            held.found       = 1'b0;
            held.overflow    = kept_dropped;
        end
        held.last_result = 1'b1;
        if (keep) pending_outliers = {pending_outliers, held};

        kept_count   = 0;
        kept_sum     = 0;
        kept_dropped = 1'b0;
    endfunction

    // Presents one sample, idling at random first, and returns once the transfer is done.
    task automatic send_sample(input logic [INTENSITY_W-1:0] x, input logic last,
                               input logic typed, input outlier_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid       <= 1'b1;
        sample_bus.intensity   <= x;
        sample_bus.last_sample <= last;
        @(posedge clk);
        while (!sample_bus.ready) @(posedge clk);
        predict_outliers(x, last, !(typed && last));
        if (typed && last) pending_outliers = {pending_outliers, want};
    endtask

    // Holds the sample channel off until every expected result has arrived.
    task automatic wait_drained();
        sample_bus.valid <= 1'b0;
        while (pending_outliers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the sigma multiple while the block is idle.
    task automatic write_sigma(input logic [SIGMA_W-1:0] value);
        wait_drained();
        cfg_bus.valid          <= 1'b1;
        cfg_bus.sigma_multiple <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        cfg_bus.valid <= 1'b0;
        model_sigma = value;
    endtask

    // Sends one random set; most sets are small, a few fill or overflow the store.
    task automatic send_random_set(output int unsigned count);
        int unsigned            size_pick;
        int unsigned            n;
        int unsigned            k;
        set_shape_t             shape;
        logic [INTENSITY_W-1:0] level;
        logic [INTENSITY_W-1:0] x;

        size_pick = $urandom_range(99);
        if (size_pick < 70)      n = $urandom_range(8, 1);
        else if (size_pick < 88) n = $urandom_range(40, 9);
        else if (size_pick < 96) n = $urandom_range(64, 41);
        else                     n = $urandom_range(70, 65);
        shape = set_shape_t'($urandom_range(3));
        level = INTENSITY_W'($urandom_range(65535 - 64));

        for (k = 0; k < n; k++) begin
            case (shape)
                SHAPE_UNIFORM: x = INTENSITY_W'($urandom_range(65535));
                SHAPE_CLUSTER: x = ($urandom_range(99) < 6)
                                   ? INTENSITY_W'($urandom_range(65535))
                                   : level + INTENSITY_W'($urandom_range(63));
                SHAPE_FLAT:    x = level;
                default:       x = ($urandom_range(99) < 8)
                                   ? INTENSITY_W'($urandom_range(65535, 60000))
                                   : INTENSITY_W'($urandom_range(15));
            endcase
            send_sample(x, k == n - 1, 1'b0, '0);
        end
        count = n;
    endtask

    // Result channel ready, idling at the current rate.
    initial begin
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge clk) begin : result_check
        outlier_t got;
        outlier_t want;

        if (rst_n && result_bus.valid && result_bus.ready) begin
            got.point_index = result_bus.point_index;
            got.found       = result_bus.found;
            got.overflow    = result_bus.overflow;
            got.last_result = result_bus.last_result;
            if (pending_outliers.size() == 0) begin
                $error("unexpected result: point_index %0d found %0b overflow %0b last %0b",
                       got.point_index, got.found, got.overflow, got.last_result);
                mismatch_count++;
            end else begin
                want = pending_outliers.pop_front();
                if (got.point_index !== want.point_index) begin
                    $error("point_index: expected %0d, actual %0d",
                           want.point_index, got.point_index);
                    mismatch_count++;
                end
                if (got.found !== want.found) begin
                    $error("found: expected %0b, actual %0b", want.found, got.found);
                    mismatch_count++;
                end
                if (got.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
                    mismatch_count++;
                end
                if (got.last_result !== want.last_result) begin
                    $error("last_result: expected %0b, actual %0b",
                           want.last_result, got.last_result);
                    mismatch_count++;
                end
            end
        end
    end

    // Reset, directed table, random sets in three idling phases, then drain and report.
    initial begin
        int unsigned random_sent;
        int unsigned set_size;
        int          r;
        int unsigned rep;
        stim_row_t   row;

        rst_n                  <= 1'b0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.sigma_multiple <= '0;
        sample_bus.valid       <= 1'b0;
        sample_bus.intensity   <= '0;
        sample_bus.last_sample <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < N_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_SIGMA) begin
                write_sigma(row.value[SIGMA_W-1:0]);
            end else begin
                for (rep = 0; rep < row.reps; rep++)
                    send_sample(row.value, row.last && (rep == row.reps - 1), row.typed,
                                row.want);
            end
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (random_sent >= RANDOM_ITEMS / 3) begin
                send_idle_pct = 78;
                recv_idle_pct = 30;
            end
            // Small multiples are favored so that outliers show up often.
            if ($urandom_range(99) < 30)
                write_sigma($urandom_range(1) ? SIGMA_W'($urandom_range(3))
                                              : SIGMA_W'($urandom_range(15)));
            send_random_set(set_size);
            random_sent += set_size;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_outliers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/stos_pkg.sv
rtl/stos_if.sv
rtl/sigma_threshold_outlier_select.sv
tb/tb_sigma_threshold_outlier_select.sv
